// ===== hw/rtl/gem_img_bitplane_rle_decoder_defines.svh =====
// Assertion macros for the GEM IMG bit-plane RLE decoder checker.
// No dependencies; taken in by the checker file.
`ifndef GEM_IMG_BITPLANE_RLE_DECODER_DEFINES_SVH
`define GEM_IMG_BITPLANE_RLE_DECODER_DEFINES_SVH

// same-cycle implication
`define GIMG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GIMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gimg_pkg.sv =====
// Shared types and constants for the GEM IMG bit-plane RLE decoder.
// No dependencies.
package gimg_pkg;

    localparam int unsigned MAX_LINE_BYTES    = 8192;
    localparam int unsigned MAX_PATTERN_BYTES = 32;
    localparam int unsigned MAX_PLANES        = 8;
    localparam int unsigned QUEUE_DEPTH       = 2;

    localparam int unsigned COL_W  = 13;
    localparam int unsigned LINE_W = 14;
    localparam int unsigned ROW_W  = 16;
    localparam int unsigned PLEN_W = 6;

    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;
    localparam logic [7:0] BYTE_BITSTR = 8'h80;

    typedef enum logic [1:0] {
        CFG_NUM_PLANES     = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_BYTES_PER_LINE = 2'd2,
        CFG_IMAGE_HEIGHT   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_MARKER  = 3'd1,
        ERR_OVERRUN = 3'd2,
        ERR_HEIGHT  = 3'd3,
        ERR_PLANES  = 3'd4
    } err_t;

    typedef enum logic [6:0] {
        PH_OPCODE     = 7'b0000001,
        PH_AFTER_ZERO = 7'b0000010,
        PH_MARKER     = 7'b0000100,
        PH_COPIES     = 7'b0001000,
        PH_PATTERN    = 7'b0010000,
        PH_AFTER_BITS = 7'b0100000,
        PH_LITERAL    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [3:0]        num_planes;
        logic [PLEN_W-1:0] pattern_length;
        logic [LINE_W-1:0] bytes_per_line;
        logic [ROW_W-1:0]  image_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_zero;
        logic       is_bitstr;
        logic       is_ones;
    } item_t;

    typedef struct packed {
        logic              write_valid;
        logic [2:0]        write_plane;
        logic [COL_W-1:0]  write_offset;
        logic [7:0]        write_data;
        logic [7:0]        repeat_count;
        logic [PLEN_W-1:0] write_stride;
        logic              line_done;
        logic [7:0]        line_copies;
        logic [ROW_W-1:0]  row_index;
        logic [2:0]        error_code;
        logic              image_done;
    } result_t;

endpackage

// ===== hw/rtl/gimg_front.sv =====
// Front end: accepts body bytes, tags the marker values and queues them.
// Depends on gimg_pkg.
module gimg_front #(
    parameter int unsigned DEPTH = gimg_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    output logic                 q_valid,
    output gimg_pkg::item_t      q_item,
    input  logic                 q_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gimg_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    gimg_pkg::item_t  item_in;
    logic             push;

    assign s_axis_tready = (count_reg != CNT_W'(DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.data      = s_axis_tdata;
        item_in.is_zero   = (s_axis_tdata == gimg_pkg::BYTE_ZERO);
        item_in.is_bitstr = (s_axis_tdata == gimg_pkg::BYTE_BITSTR);
        item_in.is_ones   = (s_axis_tdata == gimg_pkg::BYTE_ONES);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== hw/rtl/gimg_back.sv =====
// Back end: run-length parser, line/plane/row tracking and result register.
// Depends on gimg_pkg.
module gimg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gimg_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  gimg_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output gimg_pkg::result_t out_result
);

    localparam int unsigned COL_W  = gimg_pkg::COL_W;
    localparam int unsigned LINE_W = gimg_pkg::LINE_W;
    localparam int unsigned ROW_W  = gimg_pkg::ROW_W;
    localparam int unsigned PLEN_W = gimg_pkg::PLEN_W;

    gimg_pkg::phase_t  phase_reg, phase_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [2:0]        plane_reg, plane_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        left_reg, left_next;
    logic [4:0]        pos_reg, pos_next;
    logic [7:0]        rep_reg, rep_next;
    logic [7:0]        copies_reg, copies_next;
    gimg_pkg::err_t    err_reg, err_next;
    logic              done_reg, done_next;
    logic              out_valid_reg, out_valid_next;
    gimg_pkg::result_t out_result_reg, result_next;

    logic [LINE_W-1:0] bpl;
    logic [PLEN_W-1:0] plen;
    logic              planes_ok;
    logic              consume;
    logic              emit;
    logic              do_adv;
    logic [7:0]        b;
    logic [7:0]        mul_a;
    logic [LINE_W-1:0] span;
    logic [LINE_W-1:0] col_ext;
    logic [LINE_W-1:0] sum_span, sum_cnt, sum_b, sum_one, pos_off;
    logic [LINE_W-1:0] adv_col;
    logic              plane_inc_ok;
    logic [ROW_W:0]    row_end;
    logic              row_over;
    logic [7:0]        left_dec;

    always_comb
    begin
        priority if (cfg.bytes_per_line == '0)
            bpl = LINE_W'(1);
        else if (cfg.bytes_per_line > LINE_W'(gimg_pkg::MAX_LINE_BYTES))
            bpl = LINE_W'(gimg_pkg::MAX_LINE_BYTES);
        else
            bpl = cfg.bytes_per_line;
        priority if (cfg.pattern_length == '0)
            plen = PLEN_W'(1);
        else if (cfg.pattern_length > PLEN_W'(gimg_pkg::MAX_PATTERN_BYTES))
            plen = PLEN_W'(gimg_pkg::MAX_PATTERN_BYTES);
        else
            plen = cfg.pattern_length;
    end

    assign planes_ok = (cfg.num_planes == 4'd1) || (cfg.num_planes == 4'd4)
                    || (cfg.num_planes == 4'd8);

    assign consume = q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = consume;
    assign b       = q_item.data;

    // one small multiplier serves the count check and the end of a pattern run
    assign mul_a    = (phase_reg == gimg_pkg::PH_AFTER_ZERO) ? b : rep_reg;
    assign span     = {6'b0, mul_a} * {8'b0, plen};
    assign col_ext  = {1'b0, col_reg};
    assign sum_span = col_ext + span;
    assign sum_cnt  = col_ext + {7'b0, b[6:0]};
    assign sum_b    = col_ext + {6'b0, b};
    assign sum_one  = col_ext + LINE_W'(1);
    assign pos_off  = col_ext + {9'b0, pos_reg};
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        unique case (phase_reg)
            gimg_pkg::PH_OPCODE:  adv_col = sum_cnt;
            gimg_pkg::PH_PATTERN: adv_col = sum_span;
            default:              adv_col = sum_one;
        endcase
    end

    assign plane_inc_ok = ({1'b0, plane_reg} + 4'd1) < cfg.num_planes;
    assign row_end      = {1'b0, row_reg} + {9'b0, copies_reg};
    assign row_over     = row_end > {1'b0, cfg.image_height};

    always_comb
    begin
        phase_next  = phase_reg;
        col_next    = col_reg;
        plane_next  = plane_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        rep_next    = rep_reg;
        copies_next = copies_reg;
        err_next    = err_reg;
        done_next   = done_reg;
        result_next = '0;
        emit        = 1'b0;
        do_adv      = 1'b0;

        if (consume)
        begin
            priority if ((err_reg != gimg_pkg::ERR_NONE) || done_reg)
            begin
                emit = 1'b0;
            end
            else if (!planes_ok)
            begin
                err_next   = gimg_pkg::ERR_PLANES;
                phase_next = gimg_pkg::PH_OPCODE;
                emit       = 1'b1;
            end
            else if (row_reg >= cfg.image_height)
            begin
                done_next = 1'b1;
                emit      = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    gimg_pkg::PH_OPCODE:
                    begin
                        if (q_item.is_zero)
                            phase_next = gimg_pkg::PH_AFTER_ZERO;
                        else if (q_item.is_bitstr)
                            phase_next = gimg_pkg::PH_AFTER_BITS;
                        else if (sum_cnt > bpl)
                        begin
                            err_next = gimg_pkg::ERR_OVERRUN;
                            emit     = 1'b1;
                        end
                        else
                        begin
                            result_next.write_valid  = 1'b1;
                            result_next.write_plane  = plane_reg;
                            result_next.write_offset = col_reg;
                            result_next.write_data   = b[7] ? gimg_pkg::BYTE_ONES
                                                            : gimg_pkg::BYTE_ZERO;
                            result_next.repeat_count = {1'b0, b[6:0]};
                            result_next.write_stride = PLEN_W'(1);
                            do_adv = 1'b1;
                            emit   = 1'b1;
                        end
                    end
                    gimg_pkg::PH_AFTER_ZERO:
                    begin
                        if (q_item.is_zero)
                            phase_next = gimg_pkg::PH_MARKER;
                        else if (sum_span > bpl)
                        begin
                            err_next   = gimg_pkg::ERR_OVERRUN;
                            phase_next = gimg_pkg::PH_OPCODE;
                            emit       = 1'b1;
                        end
                        else
                        begin
                            rep_next   = b;
                            pos_next   = '0;
                            phase_next = gimg_pkg::PH_PATTERN;
                        end
                    end
                    gimg_pkg::PH_MARKER:
                    begin
                        phase_next = gimg_pkg::PH_OPCODE;
                        if (!q_item.is_ones)
                        begin
                            err_next = gimg_pkg::ERR_MARKER;
                            emit     = 1'b1;
                        end
                        else
                            phase_next = gimg_pkg::PH_COPIES;
                    end
                    gimg_pkg::PH_COPIES:
                    begin
                        copies_next = b;
                        phase_next  = gimg_pkg::PH_OPCODE;
                    end
                    gimg_pkg::PH_PATTERN:
                    begin
                        if (({1'b0, pos_reg} + 6'd1) >= plen)
                        begin
                            phase_next = gimg_pkg::PH_OPCODE;
                            emit       = 1'b1;
                            if (sum_span > bpl)
                                err_next = gimg_pkg::ERR_OVERRUN;
                            else
                            begin
                                result_next.write_valid  = 1'b1;
                                result_next.write_plane  = plane_reg;
                                result_next.write_offset = pos_off[COL_W-1:0];
                                result_next.write_data   = b;
                                result_next.repeat_count = rep_reg;
                                result_next.write_stride = plen;
                                pos_next = '0;
                                do_adv   = 1'b1;
                            end
                        end
                        else
                        begin
                            result_next.write_valid  = 1'b1;
                            result_next.write_plane  = plane_reg;
                            result_next.write_offset = pos_off[COL_W-1:0];
                            result_next.write_data   = b;
                            result_next.repeat_count = rep_reg;
                            result_next.write_stride = plen;
                            pos_next = pos_reg + 5'd1;
                            emit     = 1'b1;
                        end
                    end
                    gimg_pkg::PH_AFTER_BITS:
                    begin
                        phase_next = gimg_pkg::PH_OPCODE;
                        if (sum_b > bpl)
                        begin
                            err_next = gimg_pkg::ERR_OVERRUN;
                            emit     = 1'b1;
                        end
                        else if (!q_item.is_zero)
                        begin
                            left_next  = b;
                            phase_next = gimg_pkg::PH_LITERAL;
                        end
                    end
                    gimg_pkg::PH_LITERAL:
                    begin
                        emit = 1'b1;
                        if (col_ext >= bpl)
                        begin
                            err_next   = gimg_pkg::ERR_OVERRUN;
                            phase_next = gimg_pkg::PH_OPCODE;
                        end
                        else
                        begin
                            result_next.write_valid  = 1'b1;
                            result_next.write_plane  = plane_reg;
                            result_next.write_offset = col_reg;
                            result_next.write_data   = b;
                            result_next.repeat_count = 8'd1;
                            result_next.write_stride = PLEN_W'(1);
                            left_next = left_dec;
                            if (left_dec == 8'd0)
                                phase_next = gimg_pkg::PH_OPCODE;
                            do_adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = gimg_pkg::PH_OPCODE;
                    end
                endcase
            end
        end

        if (do_adv)
        begin
            if (adv_col < bpl)
                col_next = adv_col[COL_W-1:0];
            else
            begin
                col_next = '0;
                if (plane_inc_ok)
                    plane_next = plane_reg + 3'd1;
                else
                begin
                    plane_next = '0;
                    if (row_over)
                        err_next = gimg_pkg::ERR_HEIGHT;
                    else
                    begin
                        result_next.line_done   = 1'b1;
                        result_next.line_copies = copies_reg;
                        result_next.row_index   = row_reg;
                        row_next    = row_end[ROW_W-1:0];
                        copies_next = 8'd1;
                        if (row_end[ROW_W-1:0] >= cfg.image_height)
                            done_next = 1'b1;
                    end
                end
            end
        end

        if (emit)
        begin
            result_next.error_code = err_next;
            result_next.image_done = done_next;
        end

        if (consume && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= gimg_pkg::PH_OPCODE;
            col_reg       <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            rep_reg       <= '0;
            copies_reg    <= 8'd1;
            err_reg       <= gimg_pkg::ERR_NONE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            rep_reg       <= rep_next;
            copies_reg    <= copies_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            out_result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ===== hw/rtl/gem_img_bitplane_rle_decoder.sv =====
// GEM IMG body decoder: one compressed byte in per clock, plane-buffer write
// commands out, each carrying repeat count and stride so runs are never expanded.
// An accepted byte is written into the input queue, the parse step decodes it from
// the queue head and the result register loads when the byte is consumed. The
// sustained rate is one byte per clock while the output is not stalled, set by
// that parse step, and the queue keeps input flowing while a result waits on the
// output. Bytes that only open a form or carry a count or marker give no result.
// Errors and completion are sticky until reset. The user must write registers
// through the cfg channel only while the block is idle; this is not enforced.
// Depends on gimg_pkg, gimg_front and gimg_back.
module gem_img_bitplane_rle_decoder #(
    parameter int unsigned QUEUE_DEPTH = gimg_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] write_plane, [15:3] write_offset, [23:16] write_data,
    // [31:24] repeat_count, [37:32] write_stride, [45:38] line_copies,
    // [61:46] row_index, [64:62] error_code, [65] image_done, [71:66] zero
    output logic [71:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [0] write_valid, [1] line_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    gimg_pkg::cfg_t    cfg_reg;
    logic              q_valid;
    gimg_pkg::item_t   q_item;
    logic              q_pop;
    gimg_pkg::result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_planes     <= 4'd1;
            cfg_reg.pattern_length <= 6'd1;
            cfg_reg.bytes_per_line <= 14'd1;
            cfg_reg.image_height   <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gimg_pkg::CFG_NUM_PLANES:     cfg_reg.num_planes     <= cfg_data[3:0];
                gimg_pkg::CFG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[5:0];
                gimg_pkg::CFG_BYTES_PER_LINE: cfg_reg.bytes_per_line <= cfg_data[13:0];
                gimg_pkg::CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data[15:0];
            endcase
        end
    end

    gimg_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    gimg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tdata = {6'b0, res.image_done, res.error_code, res.row_index,
                           res.line_copies, res.write_stride, res.repeat_count,
                           res.write_data, res.write_offset, res.write_plane};
    assign m_axis_tuser = {res.line_done, res.write_valid};

endmodule

// ===== hw/rtl/gimg_chk.sv =====
// Port-level checker for the GEM IMG bit-plane RLE decoder, bound to the top.
// Depends on gem_img_bitplane_rle_decoder_defines.svh.
`include "gem_img_bitplane_rle_decoder_defines.svh"

module gimg_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `GIMG_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `GIMG_ASSERT_NOW(a_nowrite_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[37:0] == 38'd0, "write fields set without a write")
    `GIMG_ASSERT_NOW(a_noline_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[61:38] == 24'd0, "line fields set without line end")
    `GIMG_ASSERT_NOW(a_write_nonzero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[31:24] != 8'd0) && (m_axis_tdata[37:32] != 6'd0), "write with zero repeat or stride")

endmodule

bind gem_img_bitplane_rle_decoder gimg_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for gem_img_bitplane_rle_decoder: directed table, then random
// well-formed line streams, with a sticky error or image completion at the very end.
// Depends on gimg_pkg and the decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gimg_pkg::*;

    localparam int STIM_TARGET = 1150;

    typedef enum bit [1:0] {ROW_CFG, ROW_PRED, ROW_KNOWN, ROW_SILENT} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        cfg_index_t idx;
        logic [15:0] val;
        result_t    res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_NUM_PLANES;
    logic [15:0] cfg_data = '0;

    // decoder model: registers and parse state
    int unsigned reg_planes = 1;
    int unsigned reg_plen = 1;
    int unsigned reg_bpl = 1;
    int unsigned reg_height = 1;
    phase_t      dec_phase = PH_OPCODE;
    int unsigned dec_col = 0;
    int unsigned dec_plane = 0;
    int unsigned dec_row = 0;
    int unsigned dec_left = 0;
    int unsigned dec_pos = 0;
    int unsigned dec_rep = 0;
    int unsigned dec_copies = 1;
    err_t        dec_err = ERR_NONE;
    bit          dec_done = 1'b0;
    int          lines_closed = 0;

    result_t     due_results[$];
    int          n_sent = 0;
    int          n_fail = 0;

    gem_img_bitplane_rle_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned pattern_span();
        if (reg_plen == 0)
            return 1;
        if (reg_plen > MAX_PATTERN_BYTES)
            return MAX_PATTERN_BYTES;
        return reg_plen;
    endfunction

    function automatic int unsigned line_span();
        if (reg_bpl == 0)
            return 1;
        if (reg_bpl > MAX_LINE_BYTES)
            return MAX_LINE_BYTES;
        return reg_bpl;
    endfunction

    function automatic bit running();
        return dec_err == ERR_NONE && !dec_done;
    endfunction

    function automatic result_t write_cmd(int unsigned off, int unsigned data,
                                          int unsigned rep, int unsigned stride,
                                          bit ld, int unsigned copies, int unsigned row);
        result_t r;
        r = '0;
        r.write_valid  = 1'b1;
        r.write_offset = 13'(off);
        r.write_data   = 8'(data);
        r.repeat_count = 8'(rep);
        r.write_stride = 6'(stride);
        r.line_done    = ld;
        r.line_copies  = 8'(copies);
        r.row_index    = 16'(row);
        return r;
    endfunction

    function automatic void put_write(inout result_t r, input int unsigned off,
                                      input int unsigned data, input int unsigned rep,
                                      input int unsigned stride);
        r.write_valid  = 1'b1;
        r.write_plane  = 3'(dec_plane);
        r.write_offset = 13'(off);
        r.write_data   = 8'(data);
        r.repeat_count = 8'(rep);
        r.write_stride = 6'(stride);
    endfunction

    // column advance; closes the plane line and, after the last plane, the image line
    function automatic void close_span(input int unsigned newcol, inout result_t r);
        int unsigned last_row;
        if (newcol < line_span())
        begin
            dec_col = newcol;
            return;
        end
        dec_col = 0;
        if (dec_plane + 1 < reg_planes)
        begin
            dec_plane = (dec_plane + 1) & 7;
            return;
        end
        dec_plane = 0;
        lines_closed++;
        last_row = dec_row + dec_copies;
        if (last_row > reg_height)
        begin
            dec_err = ERR_HEIGHT;
            return;
        end
        r.line_done   = 1'b1;
        r.line_copies = 8'(dec_copies);
        r.row_index   = 16'(dec_row);
        dec_row = last_row & 16'hFFFF;
        dec_copies = 1;
        if (dec_row >= reg_height)
            dec_done = 1'b1;
    endfunction

    function automatic bit raise(input err_t code, output result_t r);
        r = '0;
        r.error_code = code;
        dec_err = code;
        dec_phase = PH_OPCODE;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output result_t r);
        int unsigned bpl;
        int unsigned plen;
        int unsigned col;
        int unsigned newcol;
        bpl = line_span();
        plen = pattern_span();
        col = dec_col;
        r = '0;
        if (!running())
            return 1'b0;
        if (!(reg_planes == 1 || reg_planes == 4 || reg_planes == 8))
            return raise(ERR_PLANES, r);
        if (dec_row >= reg_height)
        begin
            dec_done = 1'b1;
            r.image_done = 1'b1;
            return 1'b1;
        end
        case (dec_phase)
            PH_OPCODE:
            begin
                if (b == BYTE_ZERO)
                begin
                    dec_phase = PH_AFTER_ZERO;
                    return 1'b0;
                end
                if (b == BYTE_BITSTR)
                begin
                    dec_phase = PH_AFTER_BITS;
                    return 1'b0;
                end
                if (col + b[6:0] > bpl)
                    return raise(ERR_OVERRUN, r);
                put_write(r, col, b[7] ? BYTE_ONES : BYTE_ZERO, b[6:0], 1);
                close_span(col + b[6:0], r);
            end
            PH_AFTER_ZERO:
            begin
                if (b == BYTE_ZERO)
                begin
                    dec_phase = PH_MARKER;
                    return 1'b0;
                end
                if (col + b * plen > bpl)
                    return raise(ERR_OVERRUN, r);
                dec_rep = b;
                dec_pos = 0;
                dec_phase = PH_PATTERN;
                return 1'b0;
            end
            PH_MARKER:
            begin
                if (b != BYTE_ONES)
                    return raise(ERR_MARKER, r);
                dec_phase = PH_COPIES;
                return 1'b0;
            end
            PH_COPIES:
            begin
                dec_copies = b;
                dec_phase = PH_OPCODE;
                return 1'b0;
            end
            PH_PATTERN:
            begin
                if (dec_pos + 1 >= plen)
                begin
                    newcol = col + dec_rep * plen;
                    if (newcol > bpl)
                        return raise(ERR_OVERRUN, r);
                    put_write(r, col + dec_pos, b, dec_rep, plen);
                    dec_phase = PH_OPCODE;
                    dec_pos = 0;
                    close_span(newcol, r);
                end
                else
                begin
                    put_write(r, col + dec_pos, b, dec_rep, plen);
                    dec_pos = (dec_pos + 1) & 31;
                end
            end
            PH_AFTER_BITS:
            begin
                if (col + b > bpl)
                    return raise(ERR_OVERRUN, r);
                if (b == 0)
                begin
                    dec_phase = PH_OPCODE;
                    return 1'b0;
                end
                dec_left = b;
                dec_phase = PH_LITERAL;
                return 1'b0;
            end
            PH_LITERAL:
            begin
                if (col >= bpl)
                    return raise(ERR_OVERRUN, r);
                put_write(r, col, b, 1, 1);
                dec_left = (dec_left - 1) & 8'hFF;
                if (dec_left == 0)
                    dec_phase = PH_OPCODE;
                close_span(col + 1, r);
            end
            default:
            begin
                dec_phase = PH_OPCODE;
                return 1'b0;
            end
        endcase
        r.error_code = dec_err;
        r.image_done = dec_done;
        return 1'b1;
    endfunction

    function automatic int idle_pct(input bit sink);
        if (n_sent < STIM_TARGET / 3)
            return sink ? 87 : 23;
        if (n_sent < 2 * STIM_TARGET / 3)
            return sink ? 23 : 87;
        return 0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                             input bit pinned_has = 1'b0, input result_t pinned_res = '0);
        result_t r;
        bit      has;
        while ($urandom_range(99) < idle_pct(1'b0))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_sent++;
        has = decode_byte(b, r);
        if (pinned)
        begin
            has = pinned_has;
            r = pinned_res;
        end
        if (has)
            due_results.push_back(r);
    endtask

    // registers change only with the input quiet and every result collected
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NUM_PLANES:     reg_planes = val[3:0];
            CFG_PATTERN_LENGTH: reg_plen = val[5:0];
            CFG_BYTES_PER_LINE: reg_bpl = val[13:0];
            CFG_IMAGE_HEIGHT:   reg_height = val;
            default: ;
        endcase
    endtask

    // one well-formed form that fits in what is left of the plane line
    task automatic emit_form();
        int unsigned room;
        int unsigned cap;
        int unsigned n;
        int unsigned pick;
        room = line_span() - dec_col;
        pick = $urandom_range(99);
        if (pick >= 40 && pick < 60 && room >= pattern_span())
        begin
            cap = room / pattern_span();
            if (cap > 255)
                cap = 255;
            if ($urandom_range(3) != 0 && cap > 4)
                cap = 4;
            n = $urandom_range(cap, 1);
            send_byte(BYTE_ZERO);
            send_byte(8'(n));
            repeat (pattern_span()) send_byte(8'($urandom_range(255)));
        end
        else if (pick >= 60 && pick < 85)
        begin
            cap = (room > 255) ? 255 : room;
            if ($urandom_range(3) != 0 && cap > 16)
                cap = 16;
            n = $urandom_range(cap, 0);
            send_byte(BYTE_BITSTR);
            send_byte(8'(n));
            repeat (n) send_byte(8'($urandom_range(255)));
        end
        else if (pick >= 85)
        begin
            n = $urandom_range(3);
            if ($urandom_range(19) == 0)
                n = 255;
            if (dec_row + n + 256 < reg_height)
            begin
                send_byte(BYTE_ZERO);
                send_byte(BYTE_ZERO);
                send_byte(BYTE_ONES);
                send_byte(8'(n));
            end
        end
        else
        begin
            cap = (room > 127) ? 127 : room;
            n = $urandom_range(cap, 1);
            send_byte({1'($urandom_range(1)), 7'(n)});
        end
    endtask

    task automatic send_line();
        int start;
        start = lines_closed;
        while (lines_closed == start && running())
            emit_form();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.write_valid  = m_axis_tuser[0];
            got.line_done    = m_axis_tuser[1];
            got.write_plane  = m_axis_tdata[2:0];
            got.write_offset = m_axis_tdata[15:3];
            got.write_data   = m_axis_tdata[23:16];
            got.repeat_count = m_axis_tdata[31:24];
            got.write_stride = m_axis_tdata[37:32];
            got.line_copies  = m_axis_tdata[45:38];
            got.row_index    = m_axis_tdata[61:46];
            got.error_code   = m_axis_tdata[64:62];
            got.image_done   = m_axis_tdata[65];
            if (due_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                n_fail++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("write_valid", want.write_valid, got.write_valid);
                check_field("write_plane", want.write_plane, got.write_plane);
                check_field("write_offset", want.write_offset, got.write_offset);
                check_field("write_data", want.write_data, got.write_data);
                check_field("repeat_count", want.repeat_count, got.repeat_count);
                check_field("write_stride", want.write_stride, got.write_stride);
                check_field("line_done", want.line_done, got.line_done);
                check_field("line_copies", want.line_copies, got.line_copies);
                check_field("row_index", want.row_index, got.row_index);
                check_field("error_code", want.error_code, got.error_code);
                check_field("image_done", want.image_done, got.image_done);
            end
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        int unsigned phase_no;
        int unsigned planes;
        int unsigned plen;
        int unsigned bpl;
        int unsigned height;
        int unsigned target;
        int unsigned n;
        int          guard;

        rows.push_back('{ROW_CFG, CFG_NUM_PLANES, 16'd1, '0});
        rows.push_back('{ROW_CFG, CFG_PATTERN_LENGTH, 16'd2, '0});
        rows.push_back('{ROW_CFG, CFG_BYTES_PER_LINE, 16'd8, '0});
        rows.push_back('{ROW_CFG, CFG_IMAGE_HEIGHT, 16'hFFFF, '0});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'h03, write_cmd(0, 8'h00, 3, 1, 0, 0, 0)});
        // empty bit string
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h80, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h80, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h01, '0});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'hA5, write_cmd(3, 8'hA5, 1, 1, 0, 0, 0)});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h02, '0});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'h5A, write_cmd(4, 8'h5A, 2, 2, 0, 0, 0)});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'hC3, write_cmd(5, 8'hC3, 2, 2, 1, 1, 0)});
        // zero copies: line closes, row stays put
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'hFF, '0});
        rows.push_back('{ROW_SILENT, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'h88, write_cmd(0, 8'hFF, 8, 1, 1, 0, 1)});
        rows.push_back('{ROW_PRED, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_PRED, CFG_NUM_PLANES, 16'h00, '0});
        rows.push_back('{ROW_PRED, CFG_NUM_PLANES, 16'hFF, '0});
        rows.push_back('{ROW_PRED, CFG_NUM_PLANES, 16'h03, '0});
        rows.push_back('{ROW_PRED, CFG_NUM_PLANES, 16'h08, '0});
        rows.push_back('{ROW_CFG, CFG_BYTES_PER_LINE, 16'd254, '0});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'hFF, write_cmd(0, 8'hFF, 127, 1, 0, 0, 0)});
        rows.push_back('{ROW_KNOWN, CFG_NUM_PLANES, 16'h7F,
                         write_cmd(127, 8'h00, 127, 1, 1, 1, 4)});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_CFG:    write_reg(rows[i].idx, rows[i].val);
                ROW_PRED:   send_byte(rows[i].val[7:0]);
                ROW_KNOWN:  send_byte(rows[i].val[7:0], 1'b1, 1'b1, rows[i].res);
                ROW_SILENT: send_byte(rows[i].val[7:0], 1'b1, 1'b0, '0);
                default: ;
            endcase
        end

        // random phases, each starting on a line boundary
        phase_no = 0;
        while (n_sent < STIM_TARGET && dec_row < 60000)
        begin
            n = $urandom_range(2);
            planes = (n == 0) ? 1 : (n == 1) ? 4 : 8;
            plen = $urandom_range(6, 1);
            if ($urandom_range(3) == 0)
                plen = $urandom_range(32, 1);
            bpl = $urandom_range(48, 1);
            if (planes == 1 && $urandom_range(7) == 0)
                bpl = $urandom_range(600, 49);
            height = 65535;
            if ($urandom_range(1) == 0 && dec_row + 8000 < 65535)
                height = dec_row + $urandom_range(8000, 2000);
            case (phase_no)
                0: plen = 0;
                1: plen = 63;
                2:
                begin
                    plen = 32;
                    bpl = 96;
                end
                3: bpl = 0;
                4:
                begin
                    bpl = 8192;
                    planes = 1;
                end
                5:
                begin
                    bpl = 16383;
                    planes = 1;
                end
                6: planes = 8;
                7: planes = 4;
                default: ;
            endcase
            write_reg(CFG_NUM_PLANES, 16'(planes));
            write_reg(CFG_PATTERN_LENGTH, 16'(plen));
            write_reg(CFG_BYTES_PER_LINE, 16'(bpl));
            write_reg(CFG_IMAGE_HEIGHT, 16'(height));
            target = n_sent + $urandom_range(120, 40);
            while (n_sent < target && dec_row + 256 < reg_height)
                send_line();
            phase_no++;
        end

        // closing event; everything after it is ignored by the block
        case ($urandom_range(5))
            0:
            begin
                write_reg(CFG_IMAGE_HEIGHT, 16'(dec_row + 1 + $urandom_range(1)));
                while (running())
                    send_line();
            end
            1:
            begin
                send_byte(BYTE_ZERO);
                send_byte(BYTE_ZERO);
                send_byte(8'($urandom_range(254)));
            end
            2:
            begin
                bpl = $urandom_range(8, 1);
                write_reg(CFG_BYTES_PER_LINE, 16'(bpl));
                n = $urandom_range(2);
                if (n == 0)
                    send_byte({1'($urandom_range(1)), 7'($urandom_range(127, bpl + 1))});
                else
                begin
                    send_byte((n == 1) ? BYTE_BITSTR : BYTE_ZERO);
                    send_byte(8'($urandom_range(255, bpl + 1)));
                end
            end
            3:
            begin
                write_reg(CFG_IMAGE_HEIGHT, 16'(dec_row + 1 + $urandom_range(3)));
                send_byte(BYTE_ZERO);
                send_byte(BYTE_ZERO);
                send_byte(BYTE_ONES);
                send_byte(8'($urandom_range(255, 5)));
                while (running())
                    send_line();
            end
            4:
            begin
                do
                    n = $urandom_range(15);
                while (n == 1 || n == 4 || n == 8);
                write_reg(CFG_NUM_PLANES, 16'(n));
                send_byte(8'($urandom_range(255)));
            end
            default:
            begin
                write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(1) == 0) ? 16'd0 : 16'(dec_row));
                send_byte(8'($urandom_range(255)));
            end
        endcase
        repeat (8) send_byte(8'($urandom_range(255)));

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (due_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", due_results.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
